// ----- rtl/wsd_pkg.sv -----
// Package for the WebSocket frame deframer.
// Holds the transaction types of both channels and the header constants.
// Used by every module under rtl; depends on nothing.
package wsd_pkg;

  localparam int unsigned LengthBitsDefault = 64;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       truncated;
  } out_item_t;

endpackage

// ----- rtl/wsd_parser.sv -----
// Input register and frame parser of the WebSocket frame deframer.
// Tracks the header, extended length, mask key and payload count per byte.
// Depends on wsd_pkg.
module wsd_parser #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  wsd_pkg::in_item_t in_data,
  input  logic              buf_full,
  output logic              res_valid,
  output wsd_pkg::out_item_t res_data
);

  typedef enum logic [4:0] {
    PH_HDR1 = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  logic              ireg_valid;
  wsd_pkg::in_item_t ireg_data;
  logic              adv;

  phase_t                 phase, phase_next;
  logic                   masked, masked_next;
  logic [3:0]             left, left_next;
  logic [LENGTH_BITS-1:0] rem, rem_next;
  logic [31:0]            key, key_next;
  logic [1:0]             pos, pos_next;

  logic                   hit;
  wsd_pkg::out_item_t     res;
  logic [7:0]             b;
  logic [31:0]            key_shift;

  assign in_stall = ireg_valid & buf_full;
  assign adv      = ireg_valid & ~buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (!in_stall) begin
      ireg_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      ireg_data <= in_data;
    end
  end

  assign b         = ireg_data.data_byte;
  assign key_shift = key << {pos, 3'b000};

  always_comb begin
    phase_next  = phase;
    masked_next = masked;
    left_next   = left;
    rem_next    = rem;
    key_next    = key;
    pos_next    = pos;
    hit         = 1'b0;
    res         = '0;
    unique case (phase)
      PH_LEN: begin
        masked_next = b[7];
        key_next    = '0;
        pos_next    = '0;
        rem_next    = '0;
        if (b[6:0] == wsd_pkg::LenCode16) begin
          left_next  = wsd_pkg::ExtBytes16;
          phase_next = PH_EXT;
        end else if (b[6:0] == wsd_pkg::LenCode64) begin
          left_next  = wsd_pkg::ExtBytes64;
          phase_next = PH_EXT;
        end else begin
          rem_next = LENGTH_BITS'(b[6:0]);
          if (b[7]) begin
            phase_next = PH_KEY;
            left_next  = wsd_pkg::KeyBytes;
          end else if (b[6:0] == 7'd0) begin
            phase_next = PH_HDR1;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_EXT: begin
        if (rem[LENGTH_BITS-1 -: 8] != 8'd0) begin
          rem_next = '1;
        end else begin
          rem_next = {rem[LENGTH_BITS-9:0], b};
        end
        left_next = left - 4'd1;
        if (left_next == 4'd0) begin
          if (masked) begin
            phase_next = PH_KEY;
            left_next  = wsd_pkg::KeyBytes;
          end else if (rem_next == '0) begin
            phase_next = PH_HDR1;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_KEY: begin
        key_next  = {key[23:0], b};
        left_next = left - 4'd1;
        if (left_next == 4'd0) begin
          pos_next   = '0;
          phase_next = (rem == '0) ? PH_HDR1 : PH_DATA;
        end
      end
      PH_DATA: begin
        hit              = 1'b1;
        res.payload_byte = masked ? (b ^ key_shift[31:24]) : b;
        pos_next         = pos + 2'd1;
        rem_next         = rem - LENGTH_BITS'(1);
        if (rem_next == '0) begin
          res.last_of_frame = 1'b1;
          phase_next        = PH_HDR1;
        end
      end
      default: begin
        phase_next = PH_LEN;
      end
    endcase

    if (ireg_data.chunk_end && phase_next != PH_HDR1) begin
      phase_next  = PH_HDR1;
      masked_next = 1'b0;
      left_next   = '0;
      rem_next    = '0;
      key_next    = '0;
      pos_next    = '0;
      hit         = 1'b1;
      res         = '0;
      res.truncated = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HDR1;
      masked <= 1'b0;
      left   <= '0;
      rem    <= '0;
      key    <= '0;
      pos    <= '0;
    end else if (adv) begin
      phase  <= phase_next;
      masked <= masked_next;
      left   <= left_next;
      rem    <= rem_next;
      key    <= key_next;
      pos    <= pos_next;
    end
  end

  assign res_valid = adv & hit;
  assign res_data  = res;

endmodule

// ----- rtl/wsd_out_buf.sv -----
// Two-entry result buffer of the WebSocket frame deframer.
// Decouples the parser from a stalled consumer on the output channel.
// Depends on wsd_pkg.
module wsd_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wsd_pkg::out_item_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output wsd_pkg::out_item_t out_data
);

  wsd_pkg::out_item_t mem [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid & ~out_stall;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_no_push_when_full : assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("result pushed into a full buffer");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_ptr_match : assert property (@(posedge clk) disable iff (rst)
    ((count == 2'd0) || (count == 2'd2)) |-> (wr_ptr == rd_ptr))
    else $error("buffer pointers disagree with count");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("buffer count did not follow a push");
`endif

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer.
// Instantiates the parser and the result buffer; depends on wsd_pkg.
//
//   channel  direction  handshake            transaction
//   in       input      in_valid / in_stall   wsd_pkg::in_item_t
//   out      output     out_valid / out_stall wsd_pkg::out_item_t
//
// One byte is accepted per clock while the input is not stalled.
// The per-byte work is one pass of parse logic between the input register
// and the two-entry result buffer.
// Reset is synchronous and returns the parser to the first header byte.
// The input stalls only while the result buffer is full and the input
// register holds a byte.
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  wsd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wsd_pkg::out_item_t out_data
);

  logic               buf_full;
  logic               res_valid;
  wsd_pkg::out_item_t res_data;

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .buf_full (buf_full),
    .res_valid(res_valid),
    .res_data (res_data)
  );

  wsd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_data(res_data),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for websocket_frame_deframer.
// Drives directed and random frame streams, predicts each payload and truncation result
// and compares it with the block's output; depends on wsd_pkg and the RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LenBits = wsd_pkg::LengthBitsDefault;
  localparam logic [63:0] LenMax = {64{1'b1}} >> (64 - LenBits);
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ReportLimit = 10;

  typedef enum logic [4:0] {
    ParseHeader    = 5'b00001,
    ParseLength    = 5'b00010,
    ParseExtLength = 5'b00100,
    ParseMaskKey   = 5'b01000,
    ParsePayload   = 5'b10000
  } parse_phase_t;

  typedef enum int {FormShort, FormExt16, FormExt64} length_form_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  wsd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wsd_pkg::out_item_t out_data;

  parse_phase_t fr_phase;
  bit fr_masked;
  bit [3:0] hdr_left;
  bit [63:0] remaining;
  bit [31:0] mask_key;
  bit [1:0] key_pos;

  wsd_pkg::out_item_t expected_results[$];
  wsd_pkg::in_item_t pending_bytes[$];
  int unsigned bytes_sent = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;

  websocket_frame_deframer uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_parser();
    fr_phase = ParseHeader;
    fr_masked = 1'b0;
    hdr_left = '0;
    remaining = '0;
    mask_key = '0;
    key_pos = '0;
  endfunction

  function automatic void enter_after_length();
    if (fr_masked) begin
      fr_phase = ParseMaskKey;
      hdr_left = wsd_pkg::KeyBytes;
    end else if (remaining == 0) begin
      fr_phase = ParseHeader;
    end else begin
      fr_phase = ParsePayload;
    end
  endfunction

  function automatic void deframe_byte(wsd_pkg::in_item_t item);
    logic [7:0] b;
    bit emit;
    wsd_pkg::out_item_t res;
    b = item.data_byte;
    emit = 1'b0;
    res = '0;
    unique case (fr_phase)
      ParseLength: begin
        fr_masked = b[7];
        mask_key = '0;
        key_pos = '0;
        remaining = '0;
        if (b[6:0] == wsd_pkg::LenCode16) begin
          hdr_left = wsd_pkg::ExtBytes16;
          fr_phase = ParseExtLength;
        end else if (b[6:0] == wsd_pkg::LenCode64) begin
          hdr_left = wsd_pkg::ExtBytes64;
          fr_phase = ParseExtLength;
        end else begin
          remaining = 64'(b[6:0]);
          enter_after_length();
        end
      end
      ParseExtLength: begin
        if ((remaining >> (LenBits - 8)) != 0) begin
          remaining = LenMax;
        end else begin
          remaining = ((remaining << 8) | 64'(b)) & LenMax;
        end
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) begin
          enter_after_length();
        end
      end
      ParseMaskKey: begin
        mask_key = {mask_key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) begin
          key_pos = '0;
          fr_phase = (remaining == 0) ? ParseHeader : ParsePayload;
        end
      end
      ParsePayload: begin
        if (fr_masked) begin
          b = b ^ mask_key[8 * (3 - key_pos) +: 8];
        end
        key_pos = key_pos + 2'd1;
        remaining = (remaining - 64'd1) & LenMax;
        res.payload_byte = b;
        if (remaining == 0) begin
          res.last_of_frame = 1'b1;
          fr_phase = ParseHeader;
        end
        emit = 1'b1;
      end
      default: begin
        fr_phase = ParseLength;
      end
    endcase
    if (item.chunk_end && fr_phase != ParseHeader) begin
      clear_parser();
      res = '0;
      res.truncated = 1'b1;
      emit = 1'b1;
    end
    if (emit) begin
      expected_results.push_back(res);
    end
  endfunction

  function automatic void check_result(wsd_pkg::out_item_t got);
    wsd_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= ReportLimit) begin
        $display("unexpected result: byte %02h last %0b truncated %0b",
                 got.payload_byte, got.last_of_frame, got.truncated);
      end
      return;
    end
    want = expected_results.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= ReportLimit) begin
        $display("mismatch: expected byte %02h last %0b truncated %0b,",
                 want.payload_byte, want.last_of_frame, want.truncated);
        $display("          got byte %02h last %0b truncated %0b",
                 got.payload_byte, got.last_of_frame, got.truncated);
      end
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_byte(logic [7:0] b, logic last_in_chunk);
    wsd_pkg::in_item_t it;
    it.data_byte = b;
    it.chunk_end = last_in_chunk;
    pending_bytes.push_back(it);
  endfunction

  function automatic void build_frame(bit masked, length_form_t form, logic [63:0] length,
                                      int unsigned body);
    logic [6:0] code;
    push_byte(8'($urandom), 1'b0);
    case (form)
      FormShort: code = length[6:0];
      FormExt16: code = wsd_pkg::LenCode16;
      default: code = wsd_pkg::LenCode64;
    endcase
    push_byte({masked, code}, 1'b0);
    if (form == FormExt16) begin
      push_byte(length[15:8], 1'b0);
      push_byte(length[7:0], 1'b0);
    end else if (form == FormExt64) begin
      for (int i = 7; i >= 0; i--) begin
        push_byte(length[8 * i +: 8], 1'b0);
      end
    end
    if (masked) begin
      repeat (4) push_byte(8'($urandom), 1'b0);
    end
    repeat (body) push_byte(8'($urandom), 1'b0);
  endfunction

  function automatic void end_chunk_at(int unsigned idx);
    wsd_pkg::in_item_t it;
    it = pending_bytes[idx];
    it.chunk_end = 1'b1;
    pending_bytes[idx] = it;
    while (pending_bytes.size() > idx + 1) begin
      void'(pending_bytes.pop_back());
    end
  endfunction

  task automatic send_byte(wsd_pkg::in_item_t item);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(item);
    bytes_sent++;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pending();
    foreach (pending_bytes[i]) begin
      send_byte(pending_bytes[i]);
    end
    pending_bytes.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_frame();
    bit masked;
    length_form_t form;
    logic [63:0] length;
    int unsigned body;
    int unsigned r;
    masked = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 60) begin
      form = FormShort;
      length = ($urandom_range(0, 99) < 80) ? 64'($urandom_range(0, 12))
                                             : 64'($urandom_range(13, 125));
    end else if (r < 85) begin
      form = FormExt16;
      length = ($urandom_range(0, 99) < 90) ? 64'($urandom_range(0, 20))
                                             : 64'($urandom_range(0, 65535));
    end else begin
      form = FormExt64;
      length = ($urandom_range(0, 99) < 85) ? 64'($urandom_range(0, 20))
                                             : {$urandom, $urandom};
    end
    body = (length <= 300) ? int'(length) : $urandom_range(0, 20);
    build_frame(masked, form, length, body);
    r = $urandom_range(0, 99);
    if (body != length || r < 12) begin
      end_chunk_at($urandom_range(0, pending_bytes.size() - 1));
    end else if (r < 30) begin
      end_chunk_at(pending_bytes.size() - 1);
    end
    send_pending();
  endtask

  task automatic random_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    for (int unsigned i = 0; i < n; i++) begin
      push_byte(8'($urandom), (i == n - 1) ? 1'b1 : 1'($urandom_range(0, 3) == 0));
    end
    send_pending();
  endtask

  task automatic test_directed();
    // All header flag bits set, extreme payload values, chunk ending on the last byte.
    push_byte(8'hFF, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // Empty frame whose chunk ends on the length byte.
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // Masked frame with a 16-bit length; the key wraps around.
    push_byte(8'h82, 1'b0);
    push_byte({1'b1, wsd_pkg::LenCode16}, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b0);
    push_byte(8'h9A, 1'b0);
    // A 64-bit length cut off by the chunk end.
    push_byte(8'h82, 1'b0);
    push_byte({1'b0, wsd_pkg::LenCode64}, 1'b0);
    push_byte(8'hFF, 1'b1);
    // Chunk end in the middle of the payload.
    push_byte(8'h81, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h11, 1'b1);
    send_pending();
    wait_drained();
  endtask

  task automatic test_random_traffic(int unsigned count);
    int unsigned stop_at;
    idle_on = 1'b1;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 90) begin
        random_frame();
      end else begin
        random_noise();
      end
    end
    wait_drained();
  endtask

  task automatic test_streaming(int unsigned count);
    int unsigned stop_at;
    idle_on = 1'b0;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      random_frame();
    end
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_result_holdoff();
    idle_on = 1'b0;
    hold_request = 1'b1;
    build_frame(1'b1, FormShort, 64'd60, 60);
    send_pending();
    build_frame(1'b0, FormShort, 64'd20, 20);
    send_pending();
    wait_drained();
    idle_on = 1'b1;
  endtask

  initial begin : result_monitor
    int unsigned stall_left;
    int unsigned gap;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
          stall_left = gap - 1;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL websocket_frame_deframer");
        $finish;
      end
    end
  end

  initial begin
    clear_parser();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(1200);
    test_streaming(250);
    test_result_holdoff();
    test_random_traffic(200);
    wait_drained();
    if (fail_count == 0) begin
      $display("PASS websocket_frame_deframer");
    end else begin
      $display("FAIL websocket_frame_deframer");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/wsd_out_buf.sv
rtl/websocket_frame_deframer.sv
bench/testbench.sv
